### hw/rtl/grc_pkg.sv
// Shared types for the reachability closure block: controller commands,
// datapath status, request kind codes and controller state codes.
// No dependencies.
`default_nettype none

package grc_pkg;

   localparam logic [1:0] KIND_EDGE  = 2'd0;
   localparam logic [1:0] KIND_BUILD = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_CLR   = 11'b000_0000_0010,
      ST_E_RD  = 11'b000_0000_0100,
      ST_E_ROW = 11'b000_0000_1000,
      ST_E_WR  = 11'b000_0001_0000,
      ST_P_RD  = 11'b000_0010_0000,
      ST_P_LAT = 11'b000_0100_0000,
      ST_I_RD  = 11'b000_1000_0000,
      ST_I_WR  = 11'b001_0000_0000,
      ST_Q_RD  = 11'b010_0000_0000,
      ST_RESP  = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      logic edge_push;   // store the request's edge
      logic build_start; // latch vertex count, reset loop counters
      logic clr_wr;      // write identity row at sweep index
      logic edge_rd;     // fetch next stored edge
      logic adj_rd;      // read row of fetched edge's start
      logic adj_wr;      // set edge end bit in that row
      logic piv_rd;      // read pivot row
      logic piv_lat;     // latch pivot row
      logic row_rd;      // read row at sweep index
      logic row_wr;      // merge pivot row into it
      logic query_rd;    // read row of query source
      logic resp_load;   // form the answer
   } cmd_type;

   typedef struct packed {
      logic idx_last;
      logic piv_last;
      logic edge_empty;
      logic edge_done;
   } status_type;

endpackage

`default_nettype wire

### hw/rtl/grc_ctl.sv
// Controller state machine of the reachability closure block.
// Depends on grc_pkg; drives grc_dp through cmd_type, reads status_type.
`default_nettype none

module grc_ctl
   import grc_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   input  wire  [1:0] req_kind,
   input  wire        rsp_tready,
   input  status_type stat,
   output logic       req_tready,
   output logic       rsp_tvalid,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  KIND_EDGE:  cmd.edge_push = 1'b1;
                  KIND_BUILD: begin
                     cmd.build_start = 1'b1;
                     state_in        = ST_CLR;
                  end
                  KIND_QUERY: begin
                     cmd.query_rd = 1'b1;
                     state_in     = ST_Q_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_CLR: begin
            cmd.clr_wr = 1'b1;
            if (stat.idx_last)
               state_in = stat.edge_empty ? ST_P_RD : ST_E_RD;
         end
         ST_E_RD: begin
            cmd.edge_rd = 1'b1;
            state_in    = ST_E_ROW;
         end
         ST_E_ROW: begin
            cmd.adj_rd = 1'b1;
            state_in   = ST_E_WR;
         end
         ST_E_WR: begin
            cmd.adj_wr = 1'b1;
            state_in   = stat.edge_done ? ST_P_RD : ST_E_RD;
         end
         ST_P_RD: begin
            cmd.piv_rd = 1'b1;
            state_in   = ST_P_LAT;
         end
         ST_P_LAT: begin
            cmd.piv_lat = 1'b1;
            state_in    = ST_I_RD;
         end
         ST_I_RD: begin
            cmd.row_rd = 1'b1;
            state_in   = ST_I_WR;
         end
         ST_I_WR: begin
            cmd.row_wr = 1'b1;
            if (stat.idx_last)
               state_in = stat.piv_last ? ST_IDLE : ST_P_RD;
            else
               state_in = ST_I_RD;
         end
         ST_Q_RD: begin
            cmd.resp_load = 1'b1;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // never takes a request while an answer is pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("request taken during response");

   // a query always leads to a response, through ST_Q_RD into ST_RESP
   a_query_resp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == KIND_QUERY) |=> ##1 rsp_tvalid)
      else $error("query without response");

   // exactly one state bit set
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");

endmodule

`default_nettype wire

### hw/rtl/grc_dp.sv
// Datapath of the reachability closure block: edge store, reachability
// row memory, loop counters and answer registers. Depends on grc_pkg.
`default_nettype none

module grc_dp
   import grc_pkg::*;
#(
   parameter int NV = 64,
   parameter int NE = 256
) (
   input  wire        clock,
   input  wire        reset,
   input  cmd_type    cmd,
   input  wire  [6:0] req_src,
   input  wire  [6:0] req_dst,
   input  wire        csr_wr_en,
   input  wire  [6:0] csr_wr_data,
   output status_type stat,
   output logic       rsp_reach,
   output logic       rsp_dropped
);

   localparam int VW = $clog2(NV);
   localparam int EW = (NE > 1) ? $clog2(NE) : 1;
   localparam int TW = $clog2(NE + 1);

   logic [6:0]    vcount_ff, bn_ff, eff_n;
   logic [TW-1:0] total_ff, eidx_ff;
   logic          ovf_ff;
   logic [VW-1:0] idx_ff, piv_ff;

   logic [13:0]   edge_mem [NE];
   logic [13:0]   edge_q_ff;
   logic [NV-1:0] row_mem [NV];
   logic [NV-1:0] rdata_ff, pivot_ff;
   logic [VW-1:0] q_d_ff;
   logic          q_ok_ff, reach_ff;

   logic          req_ok, edge_ok, q_ok;
   logic [6:0]    es, ed;
   logic [VW-1:0] s_idx, d_idx, es_idx, ed_idx;
   logic          rd_en, we;
   logic [VW-1:0] raddr, waddr;
   logic [NV-1:0] wdata;

   assign eff_n  = (32'(vcount_ff) > NV) ? 7'(NV) : vcount_ff;
   assign req_ok = (req_src != 7'd0) && (req_src <= eff_n) &&
                   (req_dst != 7'd0) && (req_dst <= eff_n);
   assign q_ok   = req_ok && (req_src <= bn_ff) && (req_dst <= bn_ff);
   assign s_idx  = VW'(req_src - 7'd1);
   assign d_idx  = VW'(req_dst - 7'd1);

   assign es      = edge_q_ff[6:0];
   assign ed      = edge_q_ff[13:7];
   // stale edges (beyond the count latched at build) are skipped
   assign edge_ok = (es != 7'd0) && (es <= bn_ff) && (ed != 7'd0) && (ed <= bn_ff);
   assign es_idx  = VW'(es - 7'd1);
   assign ed_idx  = VW'(ed - 7'd1);

   assign stat.idx_last   = (idx_ff == VW'(NV - 1));
   assign stat.piv_last   = (piv_ff == VW'(NV - 1));
   assign stat.edge_empty = (total_ff == '0);
   assign stat.edge_done  = (eidx_ff == total_ff);

   assign rsp_reach   = reach_ff;
   assign rsp_dropped = ovf_ff;

   // read port select
   always_comb begin
      rd_en = 1'b1;
      raddr = idx_ff;
      if (cmd.query_rd)    raddr = s_idx;
      else if (cmd.adj_rd) raddr = es_idx;
      else if (cmd.piv_rd) raddr = piv_ff;
      else if (cmd.row_rd) raddr = idx_ff;
      else                 rd_en = 1'b0;
   end

   // write port select
   always_comb begin
      we    = 1'b0;
      waddr = idx_ff;
      wdata = rdata_ff;
      if (cmd.clr_wr) begin
         we    = 1'b1;
         wdata = NV'(1) << idx_ff;
      end else if (cmd.adj_wr) begin
         we    = edge_ok;
         waddr = es_idx;
         wdata = rdata_ff | (NV'(1) << ed_idx);
      end else if (cmd.row_wr) begin
         we    = 1'b1;
         wdata = rdata_ff | (rdata_ff[piv_ff] ? pivot_ff : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) rdata_ff <= row_mem[raddr];
      if (we)    row_mem[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.edge_push && req_ok && total_ff != TW'(NE))
         edge_mem[total_ff[EW-1:0]] <= {req_dst, req_src};
      if (cmd.edge_rd) edge_q_ff <= edge_mem[eidx_ff[EW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.piv_lat) pivot_ff <= rdata_ff;
      if (cmd.query_rd) begin
         q_ok_ff <= q_ok;
         q_d_ff  <= d_idx;
      end
      if (cmd.resp_load) reach_ff <= q_ok_ff & rdata_ff[q_d_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= 7'd64;
         bn_ff     <= '0;
         total_ff  <= '0;
         ovf_ff    <= 1'b0;
         eidx_ff   <= '0;
         idx_ff    <= '0;
         piv_ff    <= '0;
      end else begin
         if (csr_wr_en) vcount_ff <= csr_wr_data;
         if (cmd.edge_push && req_ok) begin
            if (total_ff == TW'(NE)) ovf_ff <= 1'b1;
            else                     total_ff <= total_ff + TW'(1);
         end
         if (cmd.build_start) begin
            bn_ff   <= eff_n;
            eidx_ff <= '0;
            idx_ff  <= '0;
            piv_ff  <= '0;
         end
         if (cmd.edge_rd) eidx_ff <= eidx_ff + TW'(1);
         if (cmd.clr_wr || cmd.row_wr)
            idx_ff <= stat.idx_last ? '0 : idx_ff + VW'(1);
         if (cmd.row_wr && stat.idx_last)
            piv_ff <= stat.piv_last ? '0 : piv_ff + VW'(1);
      end
   end

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TW'(NE)) else $error("edge count past capacity");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      $rose(ovf_ff) |-> total_ff == TW'(NE)) else $error("overflow with room left");

   a_edge_rd_range: assert property (@(posedge clock) disable iff (reset)
      cmd.edge_rd |-> eidx_ff < total_ff) else $error("edge fetch past stored count");

endmodule

`default_nettype wire

### hw/rtl/graph_reachability_closure.sv
// Reachability closure over a directed graph of up to NUM_VERTICES vertices
// and NUM_EDGES stored edges. Requests carry a kind in req_tuser: add edge,
// build, or query. A query's response holds until taken; the block takes one
// request at a time. A build clears the row memory, folds each stored edge
// into its start row (edge fetch, row read, row write: read-modify-write on
// the single row memory), then closes the rows pivot by pivot (pivot row read
// and latched, then one row read and one row write per step). Queries before
// any build, or naming a vertex outside the current count or the count in
// force at the last build, answer 0.
// Depends on grc_pkg, grc_ctl and grc_dp.
`default_nettype none

module graph_reachability_closure
   import grc_pkg::*;
#(
   parameter int NUM_VERTICES = 64,
   parameter int NUM_EDGES    = 256
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,  // [6:0] src_vertex, [13:7] dst_vertex, rest zero
   input  wire  [1:0]  req_tuser,  // [1:0] kind
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,  // [0] is_reachable, [1] edges_dropped, rest zero
   input  wire         csr_wr_en,
   input  wire  [6:0]  csr_wr_data // vertex_count
);

   cmd_type    cmd;
   status_type stat;
   logic       reach, dropped;

   // controller: sequencing of load, build sweeps and query
   grc_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   // datapath: stores, row memory and answer
   grc_dp #(
      .NV (NUM_VERTICES),
      .NE (NUM_EDGES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_src     (req_tdata[6:0]),
      .req_dst     (req_tdata[13:7]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stat        (stat),
      .rsp_reach   (reach),
      .rsp_dropped (dropped)
   );

   assign rsp_tdata = {6'd0, dropped, reach};

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for graph_reachability_closure: edge loads, builds
// and reachability queries checked against an in-bench closure predictor.
// Depends on grc_pkg and the graph_reachability_closure RTL.
`default_nettype none

module tb_top
   import grc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NV = 64;
   localparam int NE = 256;
   localparam int BUILD_GAP = NV + 3 * NE + NV * (2 + 2 * NV) + 64;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [6:0]  csr_wr_data = '0;

   always #4 clock = ~clock;

   graph_reachability_closure #(.NUM_VERTICES(NV), .NUM_EDGES(NE)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // ---------------------------------------------------------------------
   // Predictor state: edge list, sticky drop flag, closure matrix.
   // The closure is reflexive transitive closure; SCC leaders give the same
   // answers, so reach[s][d] is all that queries need.
   // ---------------------------------------------------------------------
   logic [6:0]  edge_src [NE];
   logic [6:0]  edge_dst [NE];
   int          edge_cnt;
   logic        drop_flag;
   logic [6:0]  vcount;
   logic [NV-1:0] reach [NV];
   logic [NV-1:0] built_valid;   // vertices within the count at last build

   typedef struct packed {
      logic reachable;
      logic dropped;
   } answer_type;
   answer_type answer_q[$];

   int  mismatches;
   int  gap_on;           // random idling enabled
   int  hold_off;         // long receiver stall request, in cycles

   function automatic int eff_count();
      return (vcount > NV) ? NV : int'(vcount);
   endfunction

   function automatic bit vtx_ok(logic [6:0] v);
      return v >= 1 && int'(v) <= eff_count();
   endfunction

   // Rebuild closure from the stored edges (Warshall over the valid range).
   task automatic compute_closure();
      int n;
      n = eff_count();
      built_valid = '0;
      for (int i = 0; i < NV; i++) reach[i] = '0;
      for (int i = 0; i < n; i++) begin
         reach[i][i] = 1'b1;
         built_valid[i] = 1'b1;
      end
      for (int e = 0; e < edge_cnt; e++)
         if (vtx_ok(edge_src[e]) && vtx_ok(edge_dst[e]))
            reach[edge_src[e]-1][edge_dst[e]-1] = 1'b1;
      for (int k = 0; k < n; k++)
         for (int i = 0; i < n; i++)
            if (reach[i][k]) reach[i] = reach[i] | reach[k];
   endtask

   // Apply one accepted item to the predictor.
   task automatic predict_item(logic [1:0] kind, logic [6:0] s, logic [6:0] d);
      answer_type a;
      bit ok;
      ok = vtx_ok(s) && vtx_ok(d);
      case (kind)
         KIND_EDGE: begin
            if (ok) begin
               if (edge_cnt >= NE) drop_flag = 1'b1;
               else begin
                  edge_src[edge_cnt] = s;
                  edge_dst[edge_cnt] = d;
                  edge_cnt++;
               end
            end
         end
         KIND_BUILD: compute_closure();
         KIND_QUERY: begin
            // built_valid covers the count at the last build
            a.reachable = ok && built_valid[s-1] && built_valid[d-1] && reach[s-1][d-1];
            a.dropped = drop_flag;
            answer_q.insert(answer_q.size(), a);
         end
         default: ;   // unused kind, ignored
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Sender: one item per call, with optional random idle bursts.
   // ---------------------------------------------------------------------
   task automatic send_item(logic [1:0] kind, logic [6:0] s, logic [6:0] d);
      if (gap_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, d, s};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_item(kind, s, d);
      if (kind == KIND_BUILD) begin
         // build takes long; drop valid so the next item is a fresh offer
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic idle_sender();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait till every answer has arrived, then let a build finish.
   task automatic drain(int extra);
      idle_sender();
      while (answer_q.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_count(logic [6:0] val);
      drain(BUILD_GAP);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      vcount = val;
   endtask

   // ---------------------------------------------------------------------
   // Response checker and receiver backpressure.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      answer_type exp_a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (answer_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected answer %b", rsp_tdata);
         end else begin
            exp_a = answer_q.pop_front();
            if (rsp_tdata[0] !== exp_a.reachable || rsp_tdata[1] !== exp_a.dropped
                || rsp_tdata[7:2] !== 6'd0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("answer mismatch: exp reach=%b drop=%b got tdata=%b",
                           exp_a.reachable, exp_a.dropped, rsp_tdata);
            end
         end
      end
   end

   initial begin : receiver
      int stall;
      @(negedge reset);
      forever begin
         if (hold_off > 0) begin
            rsp_tready <= 1'b0;
            stall = hold_off;
            hold_off = 0;
            repeat (stall) @(posedge clock);
         end else if (gap_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Queries before build, invalid vertices, unused kind.
   task automatic test_directed_basics();
      send_item(KIND_QUERY, 7'd1, 7'd1);      // no build yet
      send_item(KIND_EDGE, 7'd1, 7'd2);
      send_item(KIND_EDGE, 7'd2, 7'd3);
      send_item(KIND_EDGE, 7'd3, 7'd1);       // cycle 1-2-3
      send_item(KIND_EDGE, 7'd64, 7'd63);
      send_item(KIND_EDGE, 7'd0, 7'd5);       // invalid, ignored
      send_item(KIND_EDGE, 7'd5, 7'd65);      // invalid, ignored
      send_item(KIND_EDGE, 7'd127, 7'd127);
      send_item(2'd3, 7'd1, 7'd4);            // unused kind
      send_item(KIND_QUERY, 7'd1, 7'd3);      // edges not built yet
      send_item(KIND_BUILD, 7'd0, 7'd0);
      send_item(KIND_QUERY, 7'd3, 7'd2);
      send_item(KIND_QUERY, 7'd64, 7'd63);
      send_item(KIND_QUERY, 7'd63, 7'd64);
      send_item(KIND_QUERY, 7'd5, 7'd5);
      send_item(KIND_QUERY, 7'd0, 7'd0);
      send_item(KIND_QUERY, 7'd65, 7'd1);
      send_item(KIND_QUERY, 7'd127, 7'd127);
   endtask

   // Count changes: smallest, zero, clamp above 64, stale edges and queries.
   task automatic test_vertex_count();
      write_count(7'd1);
      send_item(KIND_QUERY, 7'd1, 7'd1);      // count changed, old build
      send_item(KIND_QUERY, 7'd2, 7'd2);
      send_item(KIND_BUILD, 7'd0, 7'd0);
      send_item(KIND_QUERY, 7'd1, 7'd1);
      send_item(KIND_QUERY, 7'd2, 7'd1);
      write_count(7'd0);
      send_item(KIND_EDGE, 7'd1, 7'd1);
      send_item(KIND_BUILD, 7'd0, 7'd0);
      send_item(KIND_QUERY, 7'd1, 7'd1);
      write_count(7'd127);
      send_item(KIND_BUILD, 7'd0, 7'd0);
      send_item(KIND_QUERY, 7'd2, 7'd1);
      send_item(KIND_QUERY, 7'd64, 7'd64);
   endtask

   // Random graphs: mostly edge bursts, a build, then query bursts.
   task automatic test_random_graphs(int rounds, int hi_v);
      int n;
      for (int r = 0; r < rounds; r++) begin
         n = $urandom_range(2, hi_v);
         write_count(7'(n));
         for (int i = $urandom_range(2, 3 * n / 2 + 2); i > 0; i--) begin
            if ($urandom_range(0, 9) == 0)
               send_item(2'($urandom_range(0, 3)), 7'($urandom), 7'($urandom));
            else
               send_item(KIND_EDGE, 7'($urandom_range(1, n)), 7'($urandom_range(1, n)));
         end
         send_item(KIND_BUILD, 7'($urandom), 7'($urandom));
         for (int i = $urandom_range(6, 16); i > 0; i--)
            if ($urandom_range(0, 9) == 0)
               send_item(KIND_QUERY, 7'($urandom), 7'($urandom));
            else
               send_item(KIND_QUERY, 7'($urandom_range(1, n)), 7'($urandom_range(1, n)));
      end
   endtask

   // Receiver stalls long while queries keep coming; then sender waits.
   task automatic test_backpressure();
      hold_off = 300;
      for (int i = 0; i < 20; i++)
         send_item(KIND_QUERY, 7'($urandom_range(1, 16)), 7'($urandom_range(1, 16)));
      drain(0);
   endtask

   // Fill the edge store past capacity; the sticky flag must show.
   task automatic test_overflow();
      write_count(7'd64);
      for (int i = 0; i < NE + 4; i++)
         send_item(KIND_EDGE, 7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)));
      send_item(KIND_QUERY, 7'd1, 7'd2);
      send_item(KIND_BUILD, 7'd0, 7'd0);
      for (int i = 0; i < 12; i++)
         send_item(KIND_QUERY, 7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)));
   endtask

   initial begin
      edge_cnt = 0; drop_flag = 1'b0; vcount = 7'd64; mismatches = 0;
      gap_on = 0; hold_off = 0; built_valid = '0;
      for (int i = 0; i < NV; i++) reach[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_basics();
      test_vertex_count();
      gap_on = 1;
      test_random_graphs(10, 12);
      test_backpressure();
      test_random_graphs(4, 64);
      gap_on = 0;                 // no idling in the last part
      test_random_graphs(2, 10);
      test_overflow();
      drain(200);
      if (mismatches == 0 && answer_q.size() == 0)
         $display("** graph_reachability_closure: PASSED **");
      else
         $display("** graph_reachability_closure: FAILED **");
      $finish;
   end

   initial begin
      #40ms;
      $display("** graph_reachability_closure: FAILED **");
      $finish;
   end
endmodule

`default_nettype wire
